@@ rtl/mld_pkg.sv @@
// Shared types, state codes and register indexes for the mains loss detector.
package mld_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned VoltW = 16;

	localparam logic [2:0] ST_STARTUP  = 3'd0;
	localparam logic [2:0] ST_ON       = 3'd1;
	localparam logic [2:0] ST_OFF      = 3'd2;
	localparam logic [2:0] ST_OFF_MON  = 3'd3;
	localparam logic [2:0] ST_OFF_SYNC = 3'd4;
	localparam logic [2:0] ST_ON_MON   = 3'd5;
	localparam logic [2:0] ST_ON_SYNC  = 3'd6;

	localparam logic [1:0] REP_NONE = 2'd0;
	localparam logic [1:0] REP_OFF  = 2'd1;
	localparam logic [1:0] REP_ON   = 2'd2;

	localparam logic [1:0] LED_NONE     = 2'd0;
	localparam logic [1:0] LED_SHOW_OFF = 2'd1;
	localparam logic [1:0] LED_DARK     = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_ACK    = 1'b1;

	localparam logic [1:0] CFG_OFF_THR = 2'd0;
	localparam logic [1:0] CFG_HOLD    = 2'd1;
	localparam logic [1:0] CFG_RESEND  = 2'd2;

	localparam logic [VoltW-1:0] OFF_THR_RST = 16'd1000;
	localparam logic [TimeW-1:0] HOLD_RST    = 32'd5000;
	localparam logic [TimeW-1:0] RESEND_RST  = 32'd10000;

	typedef struct packed {
		logic [VoltW-1:0] off_thr;
		logic [TimeW-1:0] hold;
		logic [TimeW-1:0] resend;
	} cfg_t;

	typedef struct packed {
		logic             op;
		logic [TimeW-1:0] now_ms;
		logic             sample_valid;
		logic [VoltW-1:0] voltage_tenths;
		logic             ack_status_on;
	} item_t;

	typedef struct packed {
		logic [2:0]       power_state;
		logic [1:0]       report_request;
		logic [1:0]       led_request;
		logic             power_is_off;
	} res_t;

	typedef struct packed {
		logic [2:0]       fsm;
		logic [TimeW-1:0] off_since;
		logic [TimeW-1:0] on_since;
		logic [TimeW-1:0] last_report;
		logic             pending_first;
		logic             acked;
	} state_t;

endpackage

@@ rtl/mld_cfg.sv @@
// Configuration register file: threshold, hold time and resend interval.
module mld_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [1:0]                   wr_index,
	input  logic [mld_pkg::TimeW-1:0]    wr_data,
	output mld_pkg::cfg_t                cfg
);

	mld_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_thr <= mld_pkg::OFF_THR_RST;
			cfg_q.hold    <= mld_pkg::HOLD_RST;
			cfg_q.resend  <= mld_pkg::RESEND_RST;
		end else if (wr_en) begin
			case (wr_index)
				mld_pkg::CFG_OFF_THR: cfg_q.off_thr <= wr_data[mld_pkg::VoltW-1:0];
				mld_pkg::CFG_HOLD:    cfg_q.hold    <= wr_data;
				mld_pkg::CFG_RESEND:  cfg_q.resend  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/mld_step.sv @@
// Next-state and result logic for one sample or acknowledge beat.
module mld_step (
	input  mld_pkg::item_t  item,
	input  mld_pkg::state_t cur,
	input  mld_pkg::cfg_t   cfg,
	output mld_pkg::state_t nxt,
	output mld_pkg::res_t   res
);

	logic [mld_pkg::VoltW-1:0] volt;
	logic                      is_off;
	logic [mld_pkg::TimeW-1:0] off_elapsed;
	logic [mld_pkg::TimeW-1:0] on_elapsed;
	logic [mld_pkg::TimeW-1:0] rep_elapsed;
	logic                      hold_off_done;
	logic                      hold_on_done;
	logic                      send_due;

	assign volt          = item.sample_valid ? item.voltage_tenths : '0;
	assign off_elapsed   = item.now_ms - cur.off_since;
	assign on_elapsed    = item.now_ms - cur.on_since;
	assign rep_elapsed   = item.now_ms - cur.last_report;
	assign hold_off_done = off_elapsed >= cfg.hold;
	assign hold_on_done  = on_elapsed >= cfg.hold;
	assign send_due      = cur.pending_first || (rep_elapsed > cfg.resend);

	always_comb begin
		nxt    = cur;
		is_off = 1'b0;
		res.report_request = mld_pkg::REP_NONE;
		res.led_request    = mld_pkg::LED_NONE;

		if (item.op == mld_pkg::OP_ACK) begin
			if (item.ack_status_on && cur.fsm == mld_pkg::ST_ON_SYNC)
				nxt.acked = 1'b1;
			if (!item.ack_status_on && cur.fsm == mld_pkg::ST_OFF_SYNC)
				nxt.acked = 1'b1;
		end else begin
			is_off = volt < cfg.off_thr;
			case (cur.fsm)
				mld_pkg::ST_ON: begin
					if (is_off) begin
						nxt.fsm       = mld_pkg::ST_OFF_MON;
						nxt.off_since = item.now_ms;
					end
				end
				mld_pkg::ST_OFF: begin
					if (!is_off) begin
						nxt.fsm      = mld_pkg::ST_ON_MON;
						nxt.on_since = item.now_ms;
					end
				end
				mld_pkg::ST_OFF_MON: begin
					if (!is_off) begin
						nxt.fsm      = mld_pkg::ST_ON_MON;
						nxt.on_since = item.now_ms;
					end else if (hold_off_done) begin
						nxt.fsm           = mld_pkg::ST_OFF_SYNC;
						nxt.acked         = 1'b0;
						nxt.pending_first = 1'b1;
					end
				end
				mld_pkg::ST_ON_MON: begin
					if (is_off) begin
						nxt.fsm       = mld_pkg::ST_OFF_MON;
						nxt.off_since = item.now_ms;
					end else if (hold_on_done) begin
						nxt.fsm           = mld_pkg::ST_ON_SYNC;
						nxt.acked         = 1'b0;
						nxt.pending_first = 1'b1;
					end
				end
				mld_pkg::ST_OFF_SYNC: begin
					if (send_due) begin
						res.report_request = mld_pkg::REP_OFF;
						nxt.last_report    = item.now_ms;
						nxt.pending_first  = 1'b0;
					end
					if (!is_off) begin
						nxt.fsm      = mld_pkg::ST_ON_MON;
						nxt.on_since = item.now_ms;
					end
					if (cur.acked) begin
						nxt.fsm         = mld_pkg::ST_OFF;
						res.led_request = mld_pkg::LED_SHOW_OFF;
					end
				end
				mld_pkg::ST_ON_SYNC: begin
					if (send_due) begin
						res.report_request = mld_pkg::REP_ON;
						nxt.last_report    = item.now_ms;
						nxt.pending_first  = 1'b0;
					end
					if (is_off) begin
						nxt.fsm       = mld_pkg::ST_OFF_MON;
						nxt.off_since = item.now_ms;
					end
					if (cur.acked) begin
						nxt.fsm         = mld_pkg::ST_ON;
						res.led_request = mld_pkg::LED_DARK;
					end
				end
				default: begin
					if (is_off) begin
						nxt.fsm       = mld_pkg::ST_OFF_MON;
						nxt.off_since = item.now_ms;
					end else begin
						nxt.fsm      = mld_pkg::ST_ON_MON;
						nxt.on_since = item.now_ms;
					end
				end
			endcase
		end

		res.power_state  = nxt.fsm;
		res.power_is_off = is_off;
	end

endmodule

@@ rtl/mains_loss_detect_sync_fsm_core.sv @@
// Mains loss detector top level: input register, state update, result register.
// Each accepted beat (voltage sample or server acknowledge) yields exactly one
// result beat. The block takes one beat per cycle while item_stall is low. The
// input register captures each accepted beat, and the result register then
// captures its result once the result register is free to take it. The rate
// is set by the state update loop, which holds the state machine and its
// three timestamps. A waiting result does not block the input
// register: the input stalls only when both the input register and the result
// register are full and the result is stalled. Configuration writes are always
// ready and take effect at once; write them only while no beat is in flight.
module mains_loss_detect_sync_fsm_core (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         op,
	input  logic [mld_pkg::TimeW-1:0]    now_ms,
	input  logic                         sample_valid,
	input  logic [mld_pkg::VoltW-1:0]    voltage_tenths,
	input  logic                         ack_status_on,

	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [2:0]                   power_state,
	output logic [1:0]                   report_request,
	output logic [1:0]                   led_request,
	output logic                         power_is_off,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [mld_pkg::TimeW-1:0]    cfg_data
);

	mld_pkg::cfg_t   cfg;
	mld_pkg::item_t  item_s1;
	logic            item_vld_s1;
	mld_pkg::res_t   res_s2;
	logic            res_vld_s2;
	mld_pkg::state_t state_q;
	mld_pkg::state_t state_nxt;
	mld_pkg::res_t   res_nxt;
	logic            out_free;
	logic            adv;
	logic            accept;

	assign cfg_ready = 1'b1;

	mld_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign out_free   = !res_vld_s2 || !result_stall;
	assign adv        = item_vld_s1 && out_free;
	assign item_stall = item_vld_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else begin
			item_vld_s1 <= accept || (item_vld_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op             <= op;
			item_s1.now_ms         <= now_ms;
			item_s1.sample_valid   <= sample_valid;
			item_s1.voltage_tenths <= voltage_tenths;
			item_s1.ack_status_on  <= ack_status_on;
		end
	end

	mld_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.fsm           <= mld_pkg::ST_STARTUP;
			state_q.off_since     <= '0;
			state_q.on_since      <= '0;
			state_q.last_report   <= '0;
			state_q.pending_first <= 1'b0;
			state_q.acked         <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else begin
			res_vld_s2 <= adv || (res_vld_s2 && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid   = res_vld_s2;
	assign power_state    = res_s2.power_state;
	assign report_request = res_s2.report_request;
	assign led_request    = res_s2.led_request;
	assign power_is_off   = res_s2.power_is_off;

`ifndef SYNTHESIS
	a_fsm_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fsm != 3'd7)
		else $error("state machine reached unused code");

	a_pending_in_sync: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending_first |->
			(state_q.fsm == mld_pkg::ST_OFF_SYNC || state_q.fsm == mld_pkg::ST_ON_SYNC))
		else $error("first report pending outside a syncing state");

	a_led_settled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && led_request != mld_pkg::LED_NONE |->
			(power_state == mld_pkg::ST_ON || power_state == mld_pkg::ST_OFF))
		else $error("LED command without settling");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_vld_s1 && !adv |=> item_vld_s1 && $stable(item_s1))
		else $error("stalled input register lost or changed its beat");

	a_state_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state changed without a beat advancing");
`endif

endmodule

@@ sim/tb_mains_loss_detect_sync_fsm_core.sv @@
// Testbench for the mains loss detector: directed and random beats checked against a predictor.

class mld_scoreboard;
	logic [15:0]   thr;
	logic [31:0]   hold;
	logic [31:0]   resend;
	logic [2:0]    fsm;
	logic [31:0]   off_since;
	logic [31:0]   on_since;
	logic [31:0]   last_rep;
	bit            first_rep;
	bit            acked;
	mld_pkg::res_t expected_res[$];
	int            errors;

	function new();
		thr       = mld_pkg::OFF_THR_RST;
		hold      = mld_pkg::HOLD_RST;
		resend    = mld_pkg::RESEND_RST;
		fsm       = mld_pkg::ST_STARTUP;
		off_since = '0;
		on_since  = '0;
		last_rep  = '0;
		first_rep = 1'b0;
		acked     = 1'b0;
		errors    = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			mld_pkg::CFG_OFF_THR: thr = data[15:0];
			mld_pkg::CFG_HOLD:    hold = data;
			mld_pkg::CFG_RESEND:  resend = data;
			default: ;
		endcase
	endfunction

	function void start_sync(logic [2:0] st);
		fsm       = st;
		acked     = 1'b0;
		first_rep = 1'b1;
	endfunction

	function void go_off_mon(logic [31:0] now);
		fsm       = mld_pkg::ST_OFF_MON;
		off_since = now;
	endfunction

	function void go_on_mon(logic [31:0] now);
		fsm      = mld_pkg::ST_ON_MON;
		on_since = now;
	endfunction

	// Advances the predicted state by one beat and queues the expected result.
	function void note_beat(mld_pkg::item_t it);
		mld_pkg::res_t r;
		logic [15:0]   volt;
		logic [31:0]   since_rep;
		bit            is_off;
		r = '0;
		if (it.op == mld_pkg::OP_ACK) begin
			if (it.ack_status_on && fsm == mld_pkg::ST_ON_SYNC)
				acked = 1'b1;
			if (!it.ack_status_on && fsm == mld_pkg::ST_OFF_SYNC)
				acked = 1'b1;
		end else begin
			volt      = it.sample_valid ? it.voltage_tenths : 16'd0;
			is_off    = volt < thr;
			since_rep = it.now_ms - last_rep;
			r.power_is_off = is_off;
			case (fsm)
				mld_pkg::ST_ON: begin
					if (is_off) go_off_mon(it.now_ms);
				end
				mld_pkg::ST_OFF: begin
					if (!is_off) go_on_mon(it.now_ms);
				end
				mld_pkg::ST_OFF_MON: begin
					if (!is_off) go_on_mon(it.now_ms);
					else if (32'(it.now_ms - off_since) >= hold) start_sync(mld_pkg::ST_OFF_SYNC);
				end
				mld_pkg::ST_ON_MON: begin
					if (is_off) go_off_mon(it.now_ms);
					else if (32'(it.now_ms - on_since) >= hold) start_sync(mld_pkg::ST_ON_SYNC);
				end
				mld_pkg::ST_OFF_SYNC: begin
					if (first_rep || since_rep > resend) begin
						r.report_request = mld_pkg::REP_OFF;
						last_rep  = it.now_ms;
						first_rep = 1'b0;
					end
					if (!is_off) go_on_mon(it.now_ms);
					if (acked) begin
						fsm = mld_pkg::ST_OFF;
						r.led_request = mld_pkg::LED_SHOW_OFF;
					end
				end
				mld_pkg::ST_ON_SYNC: begin
					if (first_rep || since_rep > resend) begin
						r.report_request = mld_pkg::REP_ON;
						last_rep  = it.now_ms;
						first_rep = 1'b0;
					end
					if (is_off) go_off_mon(it.now_ms);
					if (acked) begin
						fsm = mld_pkg::ST_ON;
						r.led_request = mld_pkg::LED_DARK;
					end
				end
				default: begin
					if (is_off) go_off_mon(it.now_ms);
					else go_on_mon(it.now_ms);
				end
			endcase
		end
		r.power_state = fsm;
		expected_res.push_back(r);
	endfunction

	task report(string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		errors++;
	endtask

	task cmp(string name, logic [2:0] got, logic [2:0] want);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task check_beat(mld_pkg::res_t got);
		mld_pkg::res_t want;
		if (expected_res.size() == 0) begin
			report($sformatf("result beat with nothing pending: %p", got));
			return;
		end
		want = expected_res.pop_front();
		cmp("power_state", got.power_state, want.power_state);
		cmp("report_request", got.report_request, want.report_request);
		cmp("led_request", got.led_request, want.led_request);
		cmp("power_is_off", got.power_is_off, want.power_is_off);
	endtask
endclass

module tb_mains_loss_detect_sync_fsm_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mld_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic              op;
	logic [TimeW-1:0]  now_ms;
	logic              sample_valid;
	logic [VoltW-1:0]  voltage_tenths;
	logic              ack_status_on;
	logic              result_valid;
	logic              result_stall;
	logic [2:0]        power_state;
	logic [1:0]        report_request;
	logic [1:0]        led_request;
	logic              power_is_off;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [TimeW-1:0]  cfg_data;

	mld_scoreboard sb = new();
	bit            quiet;
	int            n_sent;
	int            stall_left;
	int unsigned   cyc;
	logic [31:0]   ms_clock;
	bit            want_off;

	mains_loss_detect_sync_fsm_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.op             (op),
		.now_ms         (now_ms),
		.sample_valid   (sample_valid),
		.voltage_tenths (voltage_tenths),
		.ack_status_on  (ack_status_on),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.power_state    (power_state),
		.report_request (report_request),
		.led_request    (led_request),
		.power_is_off   (power_is_off),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #2 clk = ~clk;

	// result back-pressure in short bursts, with stall-free stretches
	always @(negedge clk) begin
		cyc++;
		if (stall_left == 0 && !quiet && (cyc / 128) % 3 != 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 3);
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_beat(res_t'{power_state, report_request, led_request, power_is_off});
	end

	task automatic send_beat(item_t it);
		int gap;
		if (!quiet && (n_sent / 40) % 2 == 1 && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				item_valid <= 1'b0;
			end
		end
		@(negedge clk);
		item_valid     <= 1'b1;
		op             <= it.op;
		now_ms         <= it.now_ms;
		sample_valid   <= it.sample_valid;
		voltage_tenths <= it.voltage_tenths;
		ack_status_on  <= it.ack_status_on;
		do @(posedge clk); while (item_stall);
		sb.note_beat(it);
		n_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.expected_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [15:0] thr, logic [31:0] hold, logic [31:0] resend);
		drain();
		write_reg(CFG_OFF_THR, 32'(thr));
		write_reg(CFG_HOLD, hold);
		write_reg(CFG_RESEND, resend);
	endtask

	// Mostly persistent power conditions with timestamps mostly moving forward, acks mainly while syncing.
	function automatic item_t rand_beat(int unsigned tmax);
		item_t it;
		bit    syncing;
		syncing = sb.fsm == ST_ON_SYNC || sb.fsm == ST_OFF_SYNC;
		if ((syncing && $urandom_range(0, 2) == 0) || $urandom_range(0, 19) == 0) begin
			it.op             = OP_ACK;
			it.now_ms         = $urandom;
			it.sample_valid   = 1'($urandom_range(0, 1));
			it.voltage_tenths = 16'($urandom);
			if (syncing && $urandom_range(0, 4) != 0)
				it.ack_status_on = sb.fsm == ST_ON_SYNC;
			else
				it.ack_status_on = 1'($urandom_range(0, 1));
			return it;
		end
		if ($urandom_range(0, 29) == 0)
			ms_clock = $urandom;
		else
			ms_clock += $urandom_range(0, tmax);
		if ($urandom_range(0, 5) == 0)
			want_off = !want_off;
		it.op            = OP_SAMPLE;
		it.now_ms        = ms_clock;
		it.ack_status_on = 1'($urandom_range(0, 1));
		it.sample_valid  = 1'b1;
		if (want_off && sb.thr != 0) begin
			if ($urandom_range(0, 4) == 0) begin
				it.sample_valid   = 1'b0;
				it.voltage_tenths = 16'($urandom);
			end else begin
				it.voltage_tenths = 16'($urandom_range(0, sb.thr - 1));
			end
		end else begin
			it.voltage_tenths = 16'($urandom_range(sb.thr, 16'hFFFF));
			if (sb.thr == 0)
				it.sample_valid = 1'($urandom_range(0, 1));
		end
		return it;
	endfunction

	task automatic run_random(int n, int unsigned tmax);
		repeat (n) send_beat(rand_beat(tmax));
	endtask

	task automatic directed();
		send_beat(item_t'{OP_ACK,    32'd0,          1'b0, 16'h0000, 1'b1}); // ack in startup
		send_beat(item_t'{OP_SAMPLE, 32'd100,        1'b1, 16'hFFFF, 1'b0});
		send_beat(item_t'{OP_SAMPLE, 32'd200,        1'b1, 16'd999,  1'b0}); // just below threshold
		send_beat(item_t'{OP_SAMPLE, 32'd300,        1'b1, 16'd1000, 1'b0}); // at threshold
		send_beat(item_t'{OP_SAMPLE, 32'd5299,       1'b1, 16'd2300, 1'b1}); // hold minus one
		send_beat(item_t'{OP_SAMPLE, 32'd5300,       1'b1, 16'd2300, 1'b0}); // hold reached
		send_beat(item_t'{OP_SAMPLE, 32'd5400,       1'b1, 16'd2300, 1'b0}); // first report
		send_beat(item_t'{OP_SAMPLE, 32'd15400,      1'b1, 16'd2300, 1'b0}); // resend not yet due
		send_beat(item_t'{OP_SAMPLE, 32'd15401,      1'b1, 16'd2300, 1'b0}); // resend due
		send_beat(item_t'{OP_ACK,    32'hFFFF_FFFF,  1'b1, 16'hFFFF, 1'b1});
		send_beat(item_t'{OP_SAMPLE, 32'd15500,      1'b1, 16'd2300, 1'b0}); // settle on
		send_beat(item_t'{OP_SAMPLE, 32'd15600,      1'b0, 16'hFFFF, 1'b0}); // failed read
		send_beat(item_t'{OP_SAMPLE, 32'd20600,      1'b1, 16'd0,    1'b0});
		send_beat(item_t'{OP_SAMPLE, 32'd20700,      1'b1, 16'd0,    1'b0});
		send_beat(item_t'{OP_ACK,    32'd0,          1'b0, 16'd0,    1'b0});
		send_beat(item_t'{OP_SAMPLE, 32'd20800,      1'b1, 16'd5000, 1'b0}); // flip plus ack
		send_beat(item_t'{OP_SAMPLE, 32'd20900,      1'b1, 16'd5000, 1'b0});
		send_beat(item_t'{OP_SAMPLE, 32'hFFFF_F000,  1'b1, 16'd0,    1'b0});
		send_beat(item_t'{OP_SAMPLE, 32'h0000_0388,  1'b1, 16'd0,    1'b0}); // hold across wrap
		send_beat(item_t'{OP_SAMPLE, 32'h0000_0400,  1'b1, 16'd0,    1'b0});
		send_beat(item_t'{OP_ACK,    32'd0,          1'b0, 16'd0,    1'b1}); // wrong status
		send_beat(item_t'{OP_SAMPLE, 32'h0000_0500,  1'b1, 16'hFFFF, 1'b0}); // flip, no ack
		send_beat(item_t'{OP_SAMPLE, 32'h0000_1888,  1'b1, 16'hFFFF, 1'b0});
		send_beat(item_t'{OP_SAMPLE, 32'h0000_1900,  1'b1, 16'hFFFF, 1'b0});
		send_beat(item_t'{OP_ACK,    32'd0,          1'b0, 16'd0,    1'b1});
		send_beat(item_t'{OP_SAMPLE, 32'h0000_1A00,  1'b0, 16'd0,    1'b0}); // flip plus ack
		ms_clock = 32'h0000_1A00;
	endtask

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		op             = OP_SAMPLE;
		now_ms         = '0;
		sample_valid   = 1'b0;
		voltage_tenths = '0;
		ack_status_on  = 1'b0;
		result_stall   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_OFF_THR;
		cfg_data       = '0;
		quiet          = 1'b0;
		want_off       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed();
		run_random(150, 3000);
		configure(16'd0, 32'd0, 32'd0);
		run_random(150, 3);
		configure(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(120, 1000);
		configure(16'($urandom_range(1000, 3000)), $urandom_range(0, 200), $urandom_range(0, 300));
		run_random(200, 150);
		configure(16'($urandom), $urandom, $urandom);
		run_random(150, 32'h7FFF_FFFF);
		configure(16'd2200, 32'd50, 32'd100);
		quiet = 1'b1;
		run_random(200, 60);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_res.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/mld_pkg.sv
rtl/mld_cfg.sv
rtl/mld_step.sv
rtl/mains_loss_detect_sync_fsm_core.sv
sim/tb_mains_loss_detect_sync_fsm_core.sv
